/* src/task_flag_round_robin_scheduler_core_macros.svh */
// Assertion macros shared by the scheduler checker.
`ifndef TASK_FLAG_ROUND_ROBIN_SCHEDULER_CORE_MACROS_SVH
`define TASK_FLAG_ROUND_ROBIN_SCHEDULER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TFRR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define TFRR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler assertion failed");

`endif

/* src/tfrr_pkg.sv */
// Shared types and constants of the task and flag round-robin scheduler.
package tfrr_pkg;

   localparam int NUM_TASKS = 8;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_KILL  = 2'd1;
   localparam logic [1:0] FUNC_IDLE  = 2'd2;
   localparam logic [1:0] FUNC_QUERY = 2'd3;

   localparam logic [4:0] IDLE_ID   = 5'd17;
   localparam logic [3:0] TPR_RESET = 4'd3;

   typedef struct packed {
      logic load;
      logic commit;
   } tfrr_cmd_type;

endpackage

/* src/tfrr_channels.sv */
// Channel interfaces for the request, response and register write ports.
interface tfrr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [3:0] query_task;

   modport source (output valid, output func, output query_task, input ready);
   modport sink (input valid, input func, input query_task, output ready);
endinterface

interface tfrr_rsp_if;
   logic       valid;
   logic       ready;
   logic [4:0] next_slot;
   logic [4:0] shown_task;
   logic [3:0] running_task;
   logic       in_task_phase;
   logic       idle;
   logic [7:0] alive_mask;
   logic       query_alive;
   logic       none_alive;

   modport source (output valid, output next_slot, output shown_task,
                   output running_task, output in_task_phase, output idle,
                   output alive_mask, output query_alive, output none_alive,
                   input ready);
   modport sink (input valid, input next_slot, input shown_task,
                 input running_task, input in_task_phase, input idle,
                 input alive_mask, input query_alive, input none_alive,
                 output ready);
endinterface

interface tfrr_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] tasks_per_round;

   modport source (output valid, output tasks_per_round, input ready);
   modport sink (input valid, input tasks_per_round, output ready);
endinterface

/* src/tfrr_ctrl.sv */
// Controller state machine sequencing accept, commit and response transfer.
module tfrr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output tfrr_pkg::tfrr_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign cmd.load   = req_valid && (state_ff == ST_IDLE);
   assign cmd.commit = (state_ff == ST_COMMIT) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_COMMIT;
               end
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            ST_COMMIT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
               end
            end
         endcase
      end
   end

endmodule

/* src/tfrr_datapath.sv */
// Scheduler datapath: alive bits, phase counters, task search and response register.
module tfrr_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  tfrr_pkg::tfrr_cmd_type cmd,
   input  logic [1:0]             req_func,
   input  logic [3:0]             req_query_task,
   input  logic                   csr_we,
   input  logic [3:0]             csr_tasks_per_round,
   output logic [4:0]             rsp_next_slot,
   output logic [4:0]             rsp_shown_task,
   output logic [3:0]             rsp_running_task,
   output logic                   rsp_in_task_phase,
   output logic                   rsp_idle,
   output logic [7:0]             rsp_alive_mask,
   output logic                   rsp_query_alive,
   output logic                   rsp_none_alive
);

   localparam int NUM_TASKS = tfrr_pkg::NUM_TASKS;
   localparam int TW = $clog2(NUM_TASKS + 1);
   localparam int CW = (TW > 4) ? TW : 4;
   localparam int SW = $clog2(2 * NUM_TASKS + 1);

   // The next live task after the given one, wrapping round to the lowest live task.
   function automatic logic [TW-1:0] next_alive(input logic [TW-1:0]        from,
                                                input logic [NUM_TASKS-1:0] mask);
      logic [TW-1:0] res_hi;
      logic [TW-1:0] res_lo;
      res_hi = '0;
      res_lo = '0;
      for (int j = NUM_TASKS - 1; j >= 0; j--) begin
         if (mask[j]) begin
            res_lo = TW'(j + 1);
            if (TW'(j + 1) > from) begin
               res_hi = TW'(j + 1);
            end
         end
      end
      return (res_hi != '0) ? res_hi : res_lo;
   endfunction

   logic [NUM_TASKS-1:0] alive_ff, alive_in;
   logic [3:0]           run_count_ff, run_count_in;
   logic                 task_phase_ff, task_phase_in;
   logic [TW-1:0]        current_ff, current_in;
   logic [TW-1:0]        last_ff, last_in;
   logic [TW-1:0]        alive_count_ff, alive_count_in;
   logic [TW-1:0]        flags_round_ff, flags_round_in;
   logic                 idle_ff, idle_in;
   logic [3:0]           tpr_ff;

   logic [1:0]           func_ff;
   logic [3:0]           query_ff;
   logic [TW-1:0]        cand_ff, cand_in;

   logic [NUM_TASKS-1:0] cur_hit;
   logic [NUM_TASKS-1:0] qry_hit;
   logic                 cur_alive;
   logic                 first_tick;
   logic                 task_end;
   logic                 flag_end;
   logic [TW-1:0]        from_task;
   logic [SW-1:0]        slot_in;
   logic                 none_in;
   logic                 query_alive_in;

   logic [4:0]           next_slot_ff;
   logic [4:0]           shown_task_ff;
   logic [3:0]           running_task_ff;
   logic                 in_task_phase_ff;
   logic                 idle_out_ff;
   logic [7:0]           alive_mask_ff;
   logic                 query_alive_ff;
   logic                 none_alive_ff;

   always_comb begin
      for (int j = 0; j < NUM_TASKS; j++) begin
         cur_hit[j] = (current_ff == TW'(j + 1));
         qry_hit[j] = (CW'(query_ff) == CW'(j + 1));
      end
      cur_alive  = |(alive_ff & cur_hit);
      first_tick = (current_ff == '0);
      task_end   = (run_count_ff >= tpr_ff);
      flag_end   = (CW'(run_count_ff) >= CW'(flags_round_ff));
      priority if (first_tick) begin
         from_task = '0;
      end else if (task_phase_ff) begin
         from_task = task_end ? '0 : current_ff;
      end else begin
         from_task = flag_end ? last_ff : current_ff;
      end
      cand_in = next_alive(from_task, alive_ff);
   end

   always_comb begin
      alive_in       = alive_ff;
      run_count_in   = run_count_ff;
      task_phase_in  = task_phase_ff;
      current_in     = current_ff;
      last_in        = last_ff;
      alive_count_in = alive_count_ff;
      flags_round_in = flags_round_ff;
      idle_in        = idle_ff;
      slot_in        = '0;
      none_in        = 1'b0;
      unique case (func_ff)
         tfrr_pkg::FUNC_TICK: begin
            if (alive_ff == '0) begin
               none_in = 1'b1;
            end else begin
               idle_in    = 1'b0;
               current_in = cand_ff;
               priority if (first_tick) begin
                  last_in      = cand_ff;
                  run_count_in = run_count_ff + 4'd1;
                  slot_in      = SW'(cand_ff);
               end else if (task_phase_ff && task_end) begin
                  task_phase_in  = 1'b0;
                  run_count_in   = 4'd1;
                  flags_round_in = alive_count_ff;
                  slot_in        = SW'(cand_ff) + SW'(NUM_TASKS);
               end else if (task_phase_ff) begin
                  run_count_in = run_count_ff + 4'd1;
                  last_in      = cand_ff;
                  slot_in      = SW'(cand_ff);
               end else if (flag_end) begin
                  task_phase_in = 1'b1;
                  run_count_in  = 4'd1;
                  last_in       = cand_ff;
                  slot_in       = SW'(cand_ff);
               end else begin
                  run_count_in = run_count_ff + 4'd1;
                  slot_in      = SW'(cand_ff) + SW'(NUM_TASKS);
               end
            end
         end
         tfrr_pkg::FUNC_KILL: begin
            if (!first_tick && cur_alive) begin
               alive_in = alive_ff & ~cur_hit;
               if (alive_count_ff != '0) begin
                  alive_count_in = alive_count_ff - TW'(1);
               end
            end
         end
         tfrr_pkg::FUNC_IDLE: begin
            idle_in = 1'b1;
         end
         tfrr_pkg::FUNC_QUERY: begin
         end
      endcase
      query_alive_in = |(alive_in & qry_hit);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alive_ff       <= '1;
         run_count_ff   <= 4'd0;
         task_phase_ff  <= 1'b1;
         current_ff     <= '0;
         last_ff        <= '0;
         alive_count_ff <= TW'(NUM_TASKS);
         flags_round_ff <= TW'(NUM_TASKS);
         idle_ff        <= 1'b1;
         tpr_ff         <= tfrr_pkg::TPR_RESET;
      end else begin
         if (cmd.commit) begin
            alive_ff       <= alive_in;
            run_count_ff   <= run_count_in;
            task_phase_ff  <= task_phase_in;
            current_ff     <= current_in;
            last_ff        <= last_in;
            alive_count_ff <= alive_count_in;
            flags_round_ff <= flags_round_in;
            idle_ff        <= idle_in;
         end
         if (csr_we) begin
            tpr_ff <= csr_tasks_per_round;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= req_func;
         query_ff <= req_query_task;
         cand_ff  <= cand_in;
      end
      if (cmd.commit) begin
         next_slot_ff     <= 5'(slot_in);
         shown_task_ff    <= idle_in ? tfrr_pkg::IDLE_ID : 5'(current_in);
         running_task_ff  <= 4'(current_in);
         in_task_phase_ff <= task_phase_in;
         idle_out_ff      <= idle_in;
         alive_mask_ff    <= 8'(alive_in);
         query_alive_ff   <= query_alive_in;
         none_alive_ff    <= none_in;
      end
   end

   assign rsp_next_slot     = next_slot_ff;
   assign rsp_shown_task    = shown_task_ff;
   assign rsp_running_task  = running_task_ff;
   assign rsp_in_task_phase = in_task_phase_ff;
   assign rsp_idle          = idle_out_ff;
   assign rsp_alive_mask    = alive_mask_ff;
   assign rsp_query_alive   = query_alive_ff;
   assign rsp_none_alive    = none_alive_ff;

endmodule

/* src/task_flag_round_robin_scheduler_core.sv */
// Top level of the task and flag round-robin scheduler.
// Sequence: the live-task search is registered when a request is transferred, and the commit
// step then writes the response into the output register once no earlier response waits.
// A new request is taken only after the commit step; a waiting response stalls only the
// commit step.
// Reset is synchronous and active high: all tasks alive, idle raised, tasks_per_round 3.
module task_flag_round_robin_scheduler_core (
   input  logic              clock,
   input  logic              reset,
   tfrr_req_if.sink          req_ch,
   tfrr_rsp_if.source        rsp_ch,
   tfrr_csr_if.sink          csr_ch
);

   tfrr_pkg::tfrr_cmd_type cmd;

   assign csr_ch.ready = 1'b1;

   tfrr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   tfrr_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .req_func            (req_ch.func),
      .req_query_task      (req_ch.query_task),
      .csr_we              (csr_ch.valid),
      .csr_tasks_per_round (csr_ch.tasks_per_round),
      .rsp_next_slot       (rsp_ch.next_slot),
      .rsp_shown_task      (rsp_ch.shown_task),
      .rsp_running_task    (rsp_ch.running_task),
      .rsp_in_task_phase   (rsp_ch.in_task_phase),
      .rsp_idle            (rsp_ch.idle),
      .rsp_alive_mask      (rsp_ch.alive_mask),
      .rsp_query_alive     (rsp_ch.query_alive),
      .rsp_none_alive      (rsp_ch.none_alive)
   );

endmodule

/* src/tfrr_checker.sv */
// Port-level assertion checker for the scheduler, bound to the top level.
`include "task_flag_round_robin_scheduler_core_macros.svh"

module tfrr_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [4:0] next_slot,
   input logic [4:0] shown_task,
   input logic [3:0] running_task,
   input logic       idle,
   input logic       none_alive
);

   `TFRR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(next_slot))
   `TFRR_ASSERT_NEXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready)
   `TFRR_ASSERT_NOW(a_none_no_slot, clock, reset, rsp_valid && none_alive, next_slot == 5'd0)
   `TFRR_ASSERT_NOW(a_idle_shown, clock, reset, rsp_valid && idle, shown_task == tfrr_pkg::IDLE_ID)
   `TFRR_ASSERT_NOW(a_run_shown, clock, reset, rsp_valid && !idle, shown_task == {1'b0, running_task})

endmodule

bind task_flag_round_robin_scheduler_core tfrr_checker u_tfrr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_ch.valid),
   .req_ready    (req_ch.ready),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .next_slot    (rsp_ch.next_slot),
   .shown_task   (rsp_ch.shown_task),
   .running_task (rsp_ch.running_task),
   .idle         (rsp_ch.idle),
   .none_alive   (rsp_ch.none_alive)
);

/* tb/tb_task_flag_round_robin_scheduler_core.sv */
// Self-checking testbench of the task and flag round-robin scheduler with a cycle-free predictor.
`timescale 1ns / 1ps

module tb_task_flag_round_robin_scheduler_core;

   localparam int SCHED_TASKS = tfrr_pkg::NUM_TASKS;

   typedef struct packed {
      logic [4:0] next_slot;
      logic [4:0] shown_task;
      logic [3:0] running_task;
      logic       in_task_phase;
      logic       idle;
      logic [7:0] alive_mask;
      logic       query_alive;
      logic       none_alive;
   } sched_result_type;

   logic clock = 1'b0;
   logic reset;

   tfrr_req_if req_ch ();
   tfrr_rsp_if rsp_ch ();
   tfrr_csr_if csr_ch ();

   task_flag_round_robin_scheduler_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #5 clock = ~clock;

   // Predicted scheduler state.
   logic [7:0] alive_bits;
   logic [3:0] run_cnt;
   logic       phase_is_task;
   logic [3:0] cur_task;
   logic [3:0] prev_task;
   logic [3:0] live_count;
   logic [3:0] flag_quota;
   logic       idle_on;
   logic [3:0] slots_per_round;

   sched_result_type pending_results[$];

   int mismatch_count = 0;
   int n_requests = 0;
   int n_checked = 0;
   int n_ticks = 0;
   int n_none_alive = 0;
   int n_kills = 0;
   int n_size_writes = 0;
   int burst_left = 1;
   bit sender_steady = 1'b0;
   int recv_mode = 0;
   int recv_left = 0;
   int recv_phase = 0;

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_mismatch(what, got, want);
      end
   endtask

   function automatic logic [3:0] next_live_after(logic [3:0] from);
      logic [3:0] cand;
      cand = from;
      for (int i = 0; i < SCHED_TASKS; i++) begin
         cand = (cand >= SCHED_TASKS) ? 4'd1 : cand + 4'd1;
         if (alive_bits[3'(cand - 4'd1)]) begin
            return cand;
         end
      end
      return 4'd0;
   endfunction

   task automatic reset_schedule();
      alive_bits      = 8'hFF;
      run_cnt         = 4'd0;
      phase_is_task   = 1'b1;
      cur_task        = 4'd0;
      prev_task       = 4'd0;
      live_count      = 4'd8;
      flag_quota      = 4'd8;
      idle_on         = 1'b1;
      slots_per_round = tfrr_pkg::TPR_RESET;
   endtask

   function automatic sched_result_type schedule_step(logic [1:0] f, logic [3:0] q);
      sched_result_type r;
      logic [4:0] slot;
      logic none;
      slot = 5'd0;
      none = 1'b0;
      unique case (f)
         tfrr_pkg::FUNC_TICK: begin
            n_ticks++;
            if (alive_bits == 8'h00) begin
               none = 1'b1;
               n_none_alive++;
            end else begin
               idle_on = 1'b0;
               if (cur_task == 4'd0) begin
                  cur_task  = next_live_after(4'd0);
                  prev_task = cur_task;
                  run_cnt   = run_cnt + 4'd1;
                  slot      = {1'b0, cur_task};
               end else if (phase_is_task) begin
                  if (run_cnt >= slots_per_round) begin
                     phase_is_task = 1'b0;
                     run_cnt       = 4'd1;
                     cur_task      = next_live_after(4'd0);
                     flag_quota    = live_count;
                     slot          = {1'b0, cur_task} + 5'(SCHED_TASKS);
                  end else begin
                     cur_task  = next_live_after(cur_task);
                     run_cnt   = run_cnt + 4'd1;
                     prev_task = cur_task;
                     slot      = {1'b0, cur_task};
                  end
               end else begin
                  if (run_cnt >= flag_quota) begin
                     phase_is_task = 1'b1;
                     run_cnt       = 4'd1;
                     cur_task      = next_live_after(prev_task);
                     prev_task     = cur_task;
                     slot          = {1'b0, cur_task};
                  end else begin
                     cur_task = next_live_after(cur_task);
                     run_cnt  = run_cnt + 4'd1;
                     slot     = {1'b0, cur_task} + 5'(SCHED_TASKS);
                  end
               end
            end
         end
         tfrr_pkg::FUNC_KILL: begin
            if (cur_task != 4'd0 && alive_bits[3'(cur_task - 4'd1)]) begin
               alive_bits[3'(cur_task - 4'd1)] = 1'b0;
               if (live_count > 4'd0) begin
                  live_count = live_count - 4'd1;
               end
               n_kills++;
            end
         end
         tfrr_pkg::FUNC_IDLE: begin
            idle_on = 1'b1;
         end
         default: begin
         end
      endcase
      r.next_slot     = slot;
      r.shown_task    = idle_on ? tfrr_pkg::IDLE_ID : {1'b0, cur_task};
      r.running_task  = cur_task;
      r.in_task_phase = phase_is_task;
      r.idle          = idle_on;
      r.alive_mask    = alive_bits;
      r.query_alive   = 1'b0;
      if (q >= 4'd1 && q <= SCHED_TASKS) begin
         r.query_alive = alive_bits[3'(q - 4'd1)];
      end
      r.none_alive    = none;
      return r;
   endfunction

   task automatic send_request(logic [1:0] f, logic [3:0] q);
      req_ch.valid      <= 1'b1;
      req_ch.func       <= f;
      req_ch.query_task <= q;
      do @(posedge clock); while (!req_ch.ready);
      pending_results.push_back(schedule_step(f, q));
      n_requests++;
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         req_ch.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic pace_sender();
      if (sender_steady) begin
         return;
      end
      burst_left--;
      if (burst_left <= 0) begin
         idle_gap(($urandom_range(0, 9) < 7) ? $urandom_range(1, 3) : $urandom_range(4, 20));
         burst_left = $urandom_range(1, 16);
      end
   endtask

   task automatic wait_until_drained();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_round_size(logic [3:0] value);
      wait_until_drained();
      repeat (3) @(posedge clock);
      csr_ch.valid           <= 1'b1;
      csr_ch.tasks_per_round <= value;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      slots_per_round = value;
      n_size_writes++;
   endtask

   // Kills that would drop the live count below the floor become ticks; ignored kills always pass.
   task automatic send_random_items(int count, int kill_floor, int kill_pct);
      logic [1:0] f;
      int pick;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < kill_pct) begin
            f = tfrr_pkg::FUNC_KILL;
         end else if (pick < kill_pct + 20) begin
            f = tfrr_pkg::FUNC_QUERY;
         end else if (pick < kill_pct + 32) begin
            f = tfrr_pkg::FUNC_IDLE;
         end else begin
            f = tfrr_pkg::FUNC_TICK;
         end
         if (f == tfrr_pkg::FUNC_KILL && cur_task != 4'd0 && alive_bits[3'(cur_task - 4'd1)]
             && live_count <= kill_floor) begin
            f = tfrr_pkg::FUNC_TICK;
         end
         send_request(f, 4'($urandom_range(0, 15)));
         pace_sender();
      end
   endtask

   task automatic test_directed_commands();
      send_request(tfrr_pkg::FUNC_KILL, 4'd1);
      pace_sender();
      send_request(tfrr_pkg::FUNC_QUERY, 4'd0);
      send_request(tfrr_pkg::FUNC_QUERY, 4'd15);
      send_request(tfrr_pkg::FUNC_QUERY, 4'd8);
      pace_sender();
      send_request(tfrr_pkg::FUNC_QUERY, 4'd1);
      send_request(tfrr_pkg::FUNC_IDLE, 4'd9);
      pace_sender();
      for (int i = 0; i < 4; i++) begin
         send_request(tfrr_pkg::FUNC_TICK, 4'(i + 1));
         pace_sender();
      end
      send_request(tfrr_pkg::FUNC_KILL, 4'd1);
      send_request(tfrr_pkg::FUNC_KILL, 4'd1);
      pace_sender();
      for (int i = 0; i < 8; i++) begin
         send_request(tfrr_pkg::FUNC_TICK, 4'(i + 8));
         pace_sender();
      end
      send_request(tfrr_pkg::FUNC_IDLE, 4'd2);
      send_request(tfrr_pkg::FUNC_TICK, 4'd7);
      pace_sender();
   endtask

   task automatic test_round_sizes();
      logic [3:0] sizes[8] = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd5, 4'd4, 4'd3};
      int floors[8] = '{7, 6, 6, 5, 4, 3, 2, 2};
      send_random_items(75, 7, 6);
      for (int p = 0; p < 8; p++) begin
         write_round_size(sizes[p]);
         sender_steady = (p % 3 == 1);
         send_random_items(60, floors[p], 6);
      end
      sender_steady = 1'b0;
   endtask

   task automatic test_sender_hold_off();
      send_random_items(30, 2, 4);
      wait_until_drained();
      send_random_items(30, 2, 4);
   endtask

   task automatic test_all_tasks_killed();
      write_round_size(4'd2);
      while (live_count != 4'd0) begin
         send_request($urandom_range(0, 1) ? tfrr_pkg::FUNC_KILL : tfrr_pkg::FUNC_TICK,
                      4'($urandom_range(0, 15)));
         pace_sender();
      end
      send_random_items(25, 0, 15);
   endtask

   // Response checking against the oldest predicted result.
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected response, next_slot", 32'(rsp_ch.next_slot), 32'd0);
         end else begin
            want = pending_results.pop_front();
            check_field("next_slot", 32'(rsp_ch.next_slot), 32'(want.next_slot));
            check_field("shown_task", 32'(rsp_ch.shown_task), 32'(want.shown_task));
            check_field("running_task", 32'(rsp_ch.running_task), 32'(want.running_task));
            check_field("in_task_phase", 32'(rsp_ch.in_task_phase), 32'(want.in_task_phase));
            check_field("idle", 32'(rsp_ch.idle), 32'(want.idle));
            check_field("alive_mask", 32'(rsp_ch.alive_mask), 32'(want.alive_mask));
            check_field("query_alive", 32'(rsp_ch.query_alive), 32'(want.query_alive));
            check_field("none_alive", 32'(rsp_ch.none_alive), 32'(want.none_alive));
            n_checked++;
         end
      end
   end

   // The receiver switches between full rate, light and heavy random stalls, and a fixed pattern.
   always @(posedge clock) begin
      if (recv_left == 0) begin
         recv_mode = $urandom_range(0, 3);
         recv_left = $urandom_range(10, 60);
      end
      recv_left--;
      recv_phase++;
      unique case (recv_mode)
         0: begin
            rsp_ch.ready <= 1'b1;
         end
         1: begin
            rsp_ch.ready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_ch.ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ch.ready <= (recv_phase % 5 < 2);
         end
      endcase
   end

   initial begin
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.func            <= tfrr_pkg::FUNC_QUERY;
      req_ch.query_task      <= 4'd0;
      csr_ch.valid           <= 1'b0;
      csr_ch.tasks_per_round <= tfrr_pkg::TPR_RESET;
      reset_schedule();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_commands();
      test_round_sizes();
      test_sender_hold_off();
      test_all_tasks_killed();

      wait_until_drained();
      repeat (10) @(posedge clock);
      if (pending_results.size() != 0) begin
         report_mismatch("responses still outstanding", 32'(pending_results.size()), 32'd0);
      end

      $display("Run covered %0d requests and %0d checked responses, with %0d ticks.",
               n_requests, n_checked, n_ticks);
      $display("%0d kills took effect, %0d ticks found no live task, %0d round sizes written.",
               n_kills, n_none_alive, n_size_writes);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d responses outstanding.", pending_results.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

/* sim.f */
+incdir+src
src/tfrr_pkg.sv
src/tfrr_channels.sv
src/tfrr_ctrl.sv
src/tfrr_datapath.sv
src/task_flag_round_robin_scheduler_core.sv
src/tfrr_checker.sv
tb/tb_task_flag_round_robin_scheduler_core.sv
